// ===== design/tga_pkg.sv =====
`default_nettype none
package tga_pkg;
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_PAL = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_RLE = 2'd1;
  localparam logic [1:0] REG_TOTAL = 2'd2;
  localparam logic [2:0] FMT_INDEX8 = 3'd0;
  localparam logic [2:0] FMT_RGB555 = 3'd1;
  localparam logic [2:0] FMT_BGR24 = 3'd2;
  localparam logic [2:0] FMT_BGRA32 = 3'd3;
  localparam logic [2:0] FMT_GRAY8 = 3'd4;
  localparam logic [2:0] FMT_GRAYA16 = 3'd5;

  // A completed pixel as handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  fmt;
    logic [31:0] pix;
    logic [7:0]  count;
    logic        image_end;
    logic        overrun;
  } pix_job_t;
endpackage
`default_nettype wire

// ===== design/tga_front.sv =====
`default_nettype none
module tga_front #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic [2:0]           fmt_i,
  input  wire logic                 rle_i,
  input  wire logic [23:0]          total_i,
  output      logic                 job_valid_o,
  output      tga_pkg::pix_job_t    job_o,
  input  wire logic                 q_full_i
);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [7:0]            left_q, left_d;
  logic                  run_q, run_d;
  logic [1:0]            pos_q, pos_d;
  logic [31:0]           asm_q, asm_d;
  logic [COUNT_BITS-1:0] done_q, done_d;
  logic                  fin_q, fin_d;

  logic                  acc;
  logic [2:0]            bpp;
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] remaining;
  logic [COUNT_BITS:0]   sum;
  logic [7:0]            cnt;
  logic                  ov;

  assign in_stall_o = q_full_i;
  assign acc = in_valid_i && !q_full_i;

  always_comb begin
    case (fmt_i)
      tga_pkg::FMT_INDEX8, tga_pkg::FMT_GRAY8: bpp = 3'd1;
      tga_pkg::FMT_RGB555, tga_pkg::FMT_GRAYA16: bpp = 3'd2;
      tga_pkg::FMT_BGR24: bpp = 3'd3;
      tga_pkg::FMT_BGRA32: bpp = 3'd4;
      default: bpp = 3'd0;
    endcase
  end

  always_comb begin
    logic [31:0] t;
    t = 32'(total_i);
    if (t == 32'd0) t = 32'd1;
    if (t > 32'(CountMax)) t = 32'(CountMax);
    total = t[COUNT_BITS-1:0];
  end

  assign remaining = total - done_q;

  always_comb begin
    logic [COUNT_BITS-1:0] c;
    asm_d = asm_q;
    case (pos_q)
      2'd0: asm_d[7:0] = data_byte_i;
      2'd1: asm_d[15:8] = data_byte_i;
      2'd2: asm_d[23:16] = data_byte_i;
      default: asm_d[31:24] = data_byte_i;
    endcase
    c = (rle_i && run_q && left_q != 8'd0) ? COUNT_BITS'(left_q) : COUNT_BITS'(1);
    ov = 1'b0;
    if (c > remaining) begin
      c = remaining;
      ov = 1'b1;
    end
    if (rle_i && !run_q && left_q > 8'd1 && c == remaining) ov = 1'b1;
    cnt = c[7:0];
    sum = {1'b0, done_q} + {1'b0, c};
  end

  always_comb begin
    left_d = left_q;
    run_d = run_q;
    pos_d = pos_q;
    done_d = done_q;
    fin_d = fin_q;
    job_valid_o = 1'b0;
    job_o.fmt = fmt_i;
    job_o.pix = asm_d;
    job_o.count = cnt;
    job_o.overrun = ov;
    job_o.image_end = sum[COUNT_BITS-1:0] >= total;
    if (acc) begin
      if (op_i == tga_pkg::OP_START) begin
        left_d = 8'd0;
        run_d = 1'b0;
        pos_d = 2'd0;
        done_d = '0;
        fin_d = 1'b0;
      end else if (op_i == tga_pkg::OP_DATA && !fin_q && bpp != 3'd0) begin
        if (done_q >= total) begin
          fin_d = 1'b1;
          left_d = 8'd0;
        end else if (rle_i && left_q == 8'd0) begin
          run_d = data_byte_i[7];
          left_d = {1'b0, data_byte_i[6:0]} + 8'd1;
          pos_d = 2'd0;
        end else if ({1'b0, pos_q} + 3'd1 < bpp) begin
          pos_d = pos_q + 2'd1;
        end else begin
          pos_d = 2'd0;
          job_valid_o = 1'b1;
          done_d = sum[COUNT_BITS-1:0];
          if (rle_i) left_d = (run_q || left_q == 8'd0) ? 8'd0 : left_q - 8'd1;
          if (job_o.image_end) begin
            fin_d = 1'b1;
            left_d = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      run_q <= 1'b0;
      pos_q <= '0;
      asm_q <= '0;
      done_q <= '0;
      fin_q <= 1'b0;
    end else begin
      left_q <= left_d;
      run_q <= run_d;
      pos_q <= pos_d;
      done_q <= done_d;
      fin_q <= fin_d;
      if (acc && op_i == tga_pkg::OP_START) asm_q <= '0;
      else if (acc && op_i == tga_pkg::OP_DATA && !fin_q && bpp != 3'd0 &&
               done_q < total && !(rle_i && left_q == 8'd0)) asm_q <= asm_d;
    end
  end

  a_no_job_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |-> !job_valid_o) else $error("job produced while queue full");
  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && !(acc && op_i == tga_pkg::OP_START)) |=> fin_q)
    else $error("finish flag dropped without start");
  a_end_sets_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && job_o.image_end) |=> fin_q) else $error("image end not latched");
endmodule
`default_nettype wire

// ===== design/tga_back.sv =====
`default_nettype none
module tga_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pal_we_i,
  input  wire logic [7:0]        pal_idx_i,
  input  wire logic [23:0]       pal_rgb_i,
  input  wire logic              job_valid_i,
  input  wire tga_pkg::pix_job_t job_i,
  output      logic              q_full_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [7:0]        chan_a_o,
  output      logic [7:0]        chan_b_o,
  output      logic [7:0]        chan_c_o,
  output      logic [7:0]        chan_d_o,
  output      logic [7:0]        repeat_count_o,
  output      logic              image_end_o,
  output      logic              overrun_o
);
  localparam int IdxBits = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] pal_rd_q;

  // Stage 1: job register while the palette is read. Stage 2: output register.
  logic              s1_valid_q;
  tga_pkg::pix_job_t s1_q;
  logic              s2_valid_q;
  logic              adv1;
  logic              s2_free;
  logic [15:0]       w;

  assign s2_free = !s2_valid_q || !out_stall_i;
  assign adv1 = s1_valid_q && s2_free;
  // Input is refused only when both stages are blocked.
  assign q_full_o = s1_valid_q && !s2_free;

  always_ff @(posedge clk_i) begin
    if (pal_we_i && 32'(pal_idx_i) < PALETTE_DEPTH) pal_mem[pal_idx_i[IdxBits-1:0]] <= pal_rgb_i;
    if (job_valid_i && !q_full_o)
      pal_rd_q <= (32'(job_i.pix[7:0]) < PALETTE_DEPTH) ?
                  pal_mem[job_i.pix[IdxBits-1:0]] : 24'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (!q_full_o) s1_valid_q <= job_valid_i;
      if (s2_free) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && !q_full_o) s1_q <= job_i;
  end

  assign w = s1_q.pix[15:0];

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      repeat_count_o <= s1_q.count;
      image_end_o <= s1_q.image_end;
      overrun_o <= s1_q.overrun;
      chan_d_o <= 8'hFF;
      case (s1_q.fmt)
        tga_pkg::FMT_INDEX8: begin
          chan_a_o <= pal_rd_q[23:16];
          chan_b_o <= pal_rd_q[15:8];
          chan_c_o <= pal_rd_q[7:0];
        end
        tga_pkg::FMT_RGB555: begin
          chan_a_o <= {w[14:10], 3'b0};
          chan_b_o <= {w[9:5], 3'b0};
          chan_c_o <= {w[4:0], 3'b0};
        end
        tga_pkg::FMT_BGR24: begin
          chan_a_o <= s1_q.pix[23:16];
          chan_b_o <= s1_q.pix[15:8];
          chan_c_o <= s1_q.pix[7:0];
        end
        tga_pkg::FMT_BGRA32: begin
          chan_a_o <= s1_q.pix[23:16];
          chan_b_o <= s1_q.pix[15:8];
          chan_c_o <= s1_q.pix[7:0];
          chan_d_o <= s1_q.pix[31:24];
        end
        tga_pkg::FMT_GRAY8: begin
          chan_a_o <= s1_q.pix[7:0];
          chan_b_o <= 8'd0;
          chan_c_o <= 8'd0;
        end
        default: begin
          chan_a_o <= s1_q.pix[7:0];
          chan_b_o <= s1_q.pix[15:8];
          chan_c_o <= 8'd0;
          chan_d_o <= s1_q.pix[15:8];
        end
      endcase
    end
  end

  assign out_valid_o = s2_valid_q;

  a_full_means_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_o |-> (s2_valid_q && out_stall_i)) else $error("queue full without stall");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result lost");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> repeat_count_o != 8'd0 || image_end_o) else $error("zero count");
endmodule
`default_nettype wire

// ===== design/tga_pixel_stream_decoder.sv =====
// A pixel's last byte reaches its result through the job register (with palette read), then
// the output register. Throughput: one transaction per cycle on the input unless in_stall_o
// is high; one result per cycle on the output unless out_stall_i is high.
// Reset: asynchronous, active low; clears the stream state and loads the register defaults.
// The palette memory is not cleared and is undefined until written.
`default_nettype none
module tga_pixel_stream_decoder #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  palette_index_i,
  input  wire logic [7:0]  palette_blue_i,
  input  wire logic [7:0]  palette_green_i,
  input  wire logic [7:0]  palette_red_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  chan_a_o,
  output      logic [7:0]  chan_b_o,
  output      logic [7:0]  chan_c_o,
  output      logic [7:0]  chan_d_o,
  output      logic [7:0]  repeat_count_o,
  output      logic        image_end_o,
  output      logic        overrun_o
);
  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  logic [2:0]  fmt_q;
  logic        rle_q;
  logic [23:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= tga_pkg::FMT_BGR24;
      rle_q <= 1'b0;
      total_q <= 24'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tga_pkg::REG_FORMAT: fmt_q <= cfg_data_i[2:0];
        tga_pkg::REG_RLE: rle_q <= cfg_data_i[0];
        tga_pkg::REG_TOTAL: total_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic              job_valid;
  tga_pkg::pix_job_t job;
  logic              q_full;
  logic              pal_we;

  // Palette writes go straight to the back part's memory; the front tracks the stream.
  assign pal_we = in_valid_i && !in_stall_o && op_i == tga_pkg::OP_PAL;

  tga_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .data_byte_i,
    .fmt_i(fmt_q), .rle_i(rle_q), .total_i(total_q),
    .job_valid_o(job_valid), .job_o(job), .q_full_i(q_full)
  );

  tga_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk_i, .rst_ni, .pal_we_i(pal_we), .pal_idx_i(palette_index_i),
    .pal_rgb_i({palette_red_i, palette_green_i, palette_blue_i}),
    .job_valid_i(job_valid), .job_i(job), .q_full_o(q_full),
    .out_valid_o, .out_stall_i, .chan_a_o, .chan_b_o, .chan_c_o, .chan_d_o,
    .repeat_count_o, .image_end_o, .overrun_o
  );
endmodule
`default_nettype wire

// ===== test/tb_tga_pixel_stream_decoder.sv =====
`default_nettype none
module tb_tga_pixel_stream_decoder;

  // One decoded pixel as seen on the output channel.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] cnt;
    logic       ends;
    logic       ovr;
  } rgba_pix_t;

  // Scoreboard: mirrors the decoder state and holds the pixels still owed by the DUT.
  class pixel_scoreboard;
    rgba_pix_t   pending_pix[$];
    logic [23:0] pal_mem[256];
    logic [2:0]  fmt;
    logic        rle;
    logic [23:0] total;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [1:0]  byte_pos;
    logic [31:0] assembly;
    logic [23:0] done_cnt;
    logic        finished;
    int          errors;
    int          checked;

    function new();
      fmt = tga_pkg::FMT_BGR24;
      rle = 1'b0;
      total = 24'd1;
      errors = 0;
      checked = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      pkt_left = '0;
      pkt_run = 1'b0;
      byte_pos = '0;
      assembly = '0;
      done_cnt = '0;
      finished = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      if (idx == tga_pkg::REG_FORMAT) fmt = val[2:0];
      else if (idx == tga_pkg::REG_RLE) rle = val[0];
      else if (idx == tga_pkg::REG_TOTAL) total = val;
    endfunction

    function int unsigned bpp();
      case (fmt)
        tga_pkg::FMT_INDEX8, tga_pkg::FMT_GRAY8:    return 1;
        tga_pkg::FMT_RGB555, tga_pkg::FMT_GRAYA16:  return 2;
        tga_pkg::FMT_BGR24:                         return 3;
        tga_pkg::FMT_BGRA32:                        return 4;
        default:                                    return 0;
      endcase
    endfunction

    // Accepted input transaction: update the mirrored state and queue a pixel if one completes.
    function void note(logic [1:0] op, logic [7:0] db, logic [7:0] pi,
                       logic [7:0] pb, logic [7:0] pg, logic [7:0] pr);
      rgba_pix_t   px;
      int unsigned nb;
      logic [24:0] tot_eff;
      logic [24:0] remaining;
      logic [24:0] cnt;
      logic [15:0] w;
      logic [23:0] e;
      if (op == tga_pkg::OP_PAL) begin
        pal_mem[pi] = {pr, pg, pb};
        return;
      end
      if (op == tga_pkg::OP_START) begin
        clear_stream();
        return;
      end
      if (op != tga_pkg::OP_DATA || finished) return;
      nb = bpp();
      if (nb == 0) return;
      tot_eff = (total == 0) ? 25'd1 : {1'b0, total};
      if ({1'b0, done_cnt} >= tot_eff) begin
        finished = 1'b1;
        pkt_left = '0;
        return;
      end
      if (rle && pkt_left == 0) begin
        pkt_run = db[7];
        pkt_left = {1'b0, db[6:0]} + 8'd1;
        byte_pos = '0;
        return;
      end
      assembly[8*byte_pos +: 8] = db;
      if (byte_pos + 1 < nb) begin
        byte_pos = byte_pos + 2'd1;
        return;
      end
      byte_pos = '0;
      px.d = 8'hFF;
      case (fmt)
        tga_pkg::FMT_INDEX8: begin
          e = pal_mem[assembly[7:0]];
          {px.a, px.b, px.c} = e;
        end
        tga_pkg::FMT_RGB555: begin
          w = assembly[15:0];
          px.a = {w[14:10], 3'b000};
          px.b = {w[9:5], 3'b000};
          px.c = {w[4:0], 3'b000};
        end
        tga_pkg::FMT_BGR24: begin
          px.a = assembly[23:16]; px.b = assembly[15:8]; px.c = assembly[7:0];
        end
        tga_pkg::FMT_BGRA32: begin
          px.a = assembly[23:16]; px.b = assembly[15:8]; px.c = assembly[7:0];
          px.d = assembly[31:24];
        end
        tga_pkg::FMT_GRAY8: begin
          px.a = assembly[7:0]; px.b = 8'h00; px.c = 8'h00;
        end
        default: begin
          px.a = assembly[7:0]; px.b = assembly[15:8]; px.c = 8'h00;
          px.d = assembly[15:8];
        end
      endcase
      remaining = tot_eff - {1'b0, done_cnt};
      cnt = (rle && pkt_run) ? {17'd0, pkt_left} : 25'd1;
      if (cnt == 0) cnt = 25'd1;
      px.ovr = 1'b0;
      if (cnt > remaining) begin
        cnt = remaining;
        px.ovr = 1'b1;
      end
      if (rle && !pkt_run && pkt_left > 1 && cnt == remaining) px.ovr = 1'b1;
      done_cnt = done_cnt + cnt[23:0];
      px.ends = ({1'b0, done_cnt} >= tot_eff);
      if (rle) begin
        if (pkt_run || pkt_left == 0) pkt_left = '0;
        else pkt_left = pkt_left - 8'd1;
      end
      if (px.ends) begin
        finished = 1'b1;
        pkt_left = '0;
      end
      px.cnt = cnt[7:0];
      pending_pix.push_back(px);
    endfunction

    // Compare one output transaction with the oldest pixel still owed.
    function void check(rgba_pix_t act);
      rgba_pix_t exp_px;
      checked++;
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, act);
        errors++;
        return;
      end
      exp_px = pending_pix.pop_front();
      if (act.a !== exp_px.a)
        $display("%0t: chan_a exp %h act %h", $time, exp_px.a, act.a);
      if (act.b !== exp_px.b)
        $display("%0t: chan_b exp %h act %h", $time, exp_px.b, act.b);
      if (act.c !== exp_px.c)
        $display("%0t: chan_c exp %h act %h", $time, exp_px.c, act.c);
      if (act.d !== exp_px.d)
        $display("%0t: chan_d exp %h act %h", $time, exp_px.d, act.d);
      if (act.cnt !== exp_px.cnt)
        $display("%0t: repeat_count exp %0d act %0d", $time, exp_px.cnt, act.cnt);
      if (act.ends !== exp_px.ends)
        $display("%0t: image_end exp %b act %b", $time, exp_px.ends, act.ends);
      if (act.ovr !== exp_px.ovr)
        $display("%0t: overrun exp %b act %b", $time, exp_px.ovr, act.ovr);
      if (act !== exp_px) errors++;
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = tga_pkg::OP_DATA;
  logic [7:0]  data_byte_i = '0;
  logic [7:0]  palette_index_i = '0;
  logic [7:0]  palette_blue_i = '0;
  logic [7:0]  palette_green_i = '0;
  logic [7:0]  palette_red_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  chan_a_o, chan_b_o, chan_c_o, chan_d_o, repeat_count_o;
  logic        image_end_o, overrun_o;

  pixel_scoreboard sb = new();
  bit  idling_on = 1'b1;   // cleared for the quiet tail of the run
  int  cycle_cnt = 0;
  int  txn_cnt = 0;
  int  phase_cnt = 0;

  tga_pixel_stream_decoder u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side stalls in random bursts while idling is enabled.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Every accepted output transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check('{chan_a_o, chan_b_o, chan_c_o, chan_d_o, repeat_count_o,
                 image_end_o, overrun_o});
  end

  // Drive one input transaction, optionally after a random gap, and wait until accepted.
  // Valid stays high after acceptance so back-to-back transactions need no second assignment.
  task automatic send_txn(logic [1:0] op, logic [7:0] db, logic [7:0] pi = '0,
                          logic [7:0] pb = '0, logic [7:0] pg = '0, logic [7:0] pr = '0);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    data_byte_i <= db;
    palette_index_i <= pi;
    palette_blue_i <= pb;
    palette_green_i <= pg;
    palette_red_i <= pr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(op, db, pi, pb, pg, pr);
    txn_cnt++;
  endtask

  // Hold the sender off until every owed pixel has come out and the pipe is drained.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_pix.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Registers are only written with the decoder idle.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_mode(logic [2:0] fmt, logic rle, logic [23:0] tot);
    write_reg(tga_pkg::REG_FORMAT, {21'd0, fmt});
    write_reg(tga_pkg::REG_RLE, {23'd0, rle});
    write_reg(tga_pkg::REG_TOTAL, tot);
    phase_cnt++;
  endtask

  task automatic send_pixel(int unsigned nb);
    repeat (nb) send_txn(tga_pkg::OP_DATA, 8'($urandom));
  endtask

  // One random image: mostly well-formed packets with random content, plus some noise.
  task automatic random_image();
    logic [2:0]  fmt;
    logic [23:0] tot;
    int unsigned nb;
    int unsigned sel;
    logic [7:0]  hdr;
    fmt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    sel = $urandom_range(0, 19);
    tot = (sel == 0) ? 24'd0 : (sel == 1) ? 24'hFFFFFF : 24'($urandom_range(1, 30));
    set_mode(fmt, 1'($urandom), tot);
    send_txn(tga_pkg::OP_START, 8'($urandom));
    nb = (sb.bpp() == 0) ? 1 : sb.bpp();
    repeat ($urandom_range(4, 14)) begin
      sel = $urandom_range(0, 14);
      if (sel == 0) begin
        send_txn(tga_pkg::OP_RSVD, 8'($urandom), 8'($urandom));
      end else if (sel == 1) begin
        send_txn(tga_pkg::OP_PAL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
      end else if (sel == 2) begin
        send_txn(tga_pkg::OP_START, 8'($urandom));
      end else if (sel == 3) begin
        send_txn(tga_pkg::OP_DATA, 8'($urandom));
      end else if (sb.rle) begin
        hdr = {1'($urandom), ($urandom_range(0, 9) == 0) ? 7'h7F : 7'($urandom_range(0, 6))};
        send_txn(tga_pkg::OP_DATA, hdr);
        if (hdr[7]) send_pixel(nb);
        else send_pixel(nb * (hdr[6:0] + 1));
      end else begin
        send_pixel(nb);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole palette so that every index byte reads a written entry.
    for (int i = 0; i < 256; i++)
      send_txn(tga_pkg::OP_PAL, 8'($urandom), 8'(i), 8'($urandom), 8'($urandom),
               8'($urandom));
    send_txn(tga_pkg::OP_PAL, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_txn(tga_pkg::OP_PAL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

    // Directed: every format raw, all-ones pixel then all-zeros pixel.
    for (int f = 0; f < 6; f++) begin
      set_mode(3'(f), 1'b0, 24'd2);
      send_txn(tga_pkg::OP_START, 8'h00);
      repeat (sb.bpp()) send_txn(tga_pkg::OP_DATA, 8'hFF);
      repeat (sb.bpp()) send_txn(tga_pkg::OP_DATA, 8'h00);
      send_txn(tga_pkg::OP_DATA, 8'h5A);   // bytes after the image end are dropped
    end
    // Run longer than the image: clamped with overrun.
    set_mode(tga_pkg::FMT_GRAY8, 1'b1, 24'd5);
    send_txn(tga_pkg::OP_START, 8'h00);
    send_txn(tga_pkg::OP_DATA, 8'hFF);
    send_txn(tga_pkg::OP_DATA, 8'h80);
    // Literal packet longer than the image, then the unused opcode.
    set_mode(tga_pkg::FMT_GRAY8, 1'b1, 24'd2);
    send_txn(tga_pkg::OP_START, 8'h00);
    send_txn(tga_pkg::OP_DATA, 8'h7F);
    repeat (3) send_txn(tga_pkg::OP_DATA, 8'h33);
    send_txn(tga_pkg::OP_RSVD, 8'hFF, 8'hFF);
    // Total lowered below progress: the next byte ends the image silently.
    set_mode(tga_pkg::FMT_GRAY8, 1'b0, 24'd10);
    send_txn(tga_pkg::OP_START, 8'h00);
    repeat (4) send_txn(tga_pkg::OP_DATA, 8'h11);
    write_reg(tga_pkg::REG_TOTAL, 24'd2);
    send_txn(tga_pkg::OP_DATA, 8'h22);
    // Unsupported format drops bytes; zero total acts as one.
    set_mode(3'd7, 1'b0, 24'd0);
    send_txn(tga_pkg::OP_START, 8'h00);
    send_txn(tga_pkg::OP_DATA, 8'h44);
    set_mode(tga_pkg::FMT_BGR24, 1'b0, 24'd0);
    send_txn(tga_pkg::OP_DATA, 8'h01);
    send_txn(tga_pkg::OP_DATA, 8'h02);
    send_txn(tga_pkg::OP_DATA, 8'h03);

    // Random images; the tail of the run has no idling on either side.
    while (txn_cnt < 600) begin
      if (txn_cnt > 520) idling_on = 1'b0;
      random_image();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.pending_pix.size() != 0) begin
      $display("%0t: %0d pixels never came out", $time, sb.pending_pix.size());
      sb.errors++;
    end
    $display("Covered %0d input transactions over %0d mode settings, %0d pixels checked.",
             txn_cnt, phase_cnt, sb.checked);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
